### hdl/object_reference_parser_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the object reference parser.
// Both macros expect signals named clk and rst_n in the scope where they
// are used.
// ----------------------------------------------------------------------------
`ifndef OBJECT_REFERENCE_PARSER_TOP_MACROS_SVH
`define OBJECT_REFERENCE_PARSER_TOP_MACROS_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define ORP_ASSERT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion violated in %m");

// The consequent must hold in the cycle after the antecedent.
`define ORP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion violated in %m");

`else

`define ORP_ASSERT(label, ante, cons)

`define ORP_ASSERT_NEXT(label, ante, cons)

`endif

`endif

### hdl/orp_pkg.sv
// ----------------------------------------------------------------------------
// Object reference parser package
// Widths, character codes, parse phases, byte roles and the result record.
// ----------------------------------------------------------------------------
package orp_pkg;

    localparam int VALUE_WIDTH = 63;
    localparam int OUT_WIDTH   = 63;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_Z      = 8'h7A;
    localparam logic [7:0] CH_E      = 8'h65;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_O      = 8'h6F;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_EQUALS = 8'h3D;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_DIG0   = 8'h30;
    localparam logic [7:0] CH_DIG9   = 8'h39;
    localparam logic [7:0] CH_HEXA   = 8'h61;
    localparam logic [7:0] CH_HEXF   = 8'h66;

    localparam logic [2:0] KW_LEN = 3'd4;

    typedef enum logic [3:0] {
        PH_START,
        PH_KEYWORD,
        PH_SEGMENT,
        PH_OBJECT,
        PH_AFTER_KW,
        PH_CHECKSUM,
        PH_AFTER_CK,
        PH_RNG_OPEN,
        PH_RNG_1,
        PH_RNG_2,
        PH_DONE
    } phase_t;

    typedef enum logic [2:0] {
        ROLE_IGNORED,
        ROLE_KEYWORD,
        ROLE_SEGMENT,
        ROLE_SLASH,
        ROLE_OBJECT,
        ROLE_CHECKSUM,
        ROLE_RANGE_SYN,
        ROLE_RANGE_DIG
    } role_t;

    typedef struct packed {
        role_t                  role;
        logic                   final_res;
        logic                   status;
        logic                   ref_kind;
        logic                   has_checksum;
        logic                   has_range;
        logic                   exact;
        logic [OUT_WIDTH-1:0]   range_first;
        logic [OUT_WIDTH-1:0]   range_len;
    } result_t;

    function automatic logic is_dig(input logic [7:0] c);
        return (c >= CH_DIG0) && (c <= CH_DIG9);
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return is_dig(c) || ((c >= CH_HEXA) && (c <= CH_HEXF));
    endfunction

    // Letters of the keyword "zero" by position.
    function automatic logic [7:0] kw_char(input logic [1:0] idx);
        logic [7:0] c;
        unique case (idx)
            2'd0:    c = CH_Z;
            2'd1:    c = CH_E;
            2'd2:    c = CH_R;
            default: c = CH_O;
        endcase
        return c;
    endfunction

endpackage

### hdl/orp_ifs.sv
// ----------------------------------------------------------------------------
// Object reference parser channels
// Valid/ready channels for character beats and result beats.
// ----------------------------------------------------------------------------
interface orp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       last;

    modport source (output valid, output ch, output last, input ready);
    modport sink   (input valid, input ch, input last, output ready);
endinterface

interface orp_out_if;
    logic                           valid;
    logic                           ready;
    logic [2:0]                     role;
    logic                           final_res;
    logic                           status;
    logic                           ref_kind;
    logic                           has_checksum;
    logic                           has_range;
    logic                           exact;
    logic [orp_pkg::OUT_WIDTH-1:0]  range_first;
    logic [orp_pkg::OUT_WIDTH-1:0]  range_len;

    modport source (output valid, output role, output final_res, output status,
                    output ref_kind, output has_checksum, output has_range,
                    output exact, output range_first, output range_len,
                    input ready);
    modport sink   (input valid, input role, input final_res, input status,
                    input ref_kind, input has_checksum, input has_range,
                    input exact, input range_first, input range_len,
                    output ready);
endinterface

### hdl/orp_parser.sv
// ----------------------------------------------------------------------------
// Object reference parser core
// Holds the parse state and classifies one character per accepted beat.
// ----------------------------------------------------------------------------
module orp_parser (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             fire,
    input  logic [7:0]       ch,
    input  logic             last,
    output orp_pkg::result_t res
);
    import orp_pkg::*;

`include "object_reference_parser_top_macros.svh"

    phase_t                 phase_reg,   phase_next;
    logic [2:0]             kw_reg,      kw_next;
    logic                   kind_reg,    kind_next;
    logic                   ck_reg,      ck_next;
    logic                   has_rng_reg, has_rng_next;
    logic                   exact_reg,   exact_next;
    logic [VALUE_WIDTH-1:0] start_reg,   start_next;
    logic [VALUE_WIDTH-1:0] acc_reg,     acc_next;
    logic [VALUE_WIDTH-1:0] len_reg,     len_next;
    logic                   err_reg,     err_next;

    role_t                  role;
    logic                   fin_err;
    logic [VALUE_WIDTH+3:0] acc_wide;
    logic [VALUE_WIDTH-1:0] acc_dig;

    // Decimal step acc*10 + digit as two shifted adds; any carry into the
    // top four bits means the value passed the maximum and saturates.
    always_comb
    begin
        acc_wide = ({4'b0, acc_reg} << 3) + ({4'b0, acc_reg} << 1)
                 + (VALUE_WIDTH+4)'(ch[3:0]);
        acc_dig  = (acc_wide[VALUE_WIDTH+3:VALUE_WIDTH] != 4'b0) ? '1
                 : acc_wide[VALUE_WIDTH-1:0];
    end

    always_comb
    begin
        phase_next   = phase_reg;
        kw_next      = kw_reg;
        kind_next    = kind_reg;
        ck_next      = ck_reg;
        has_rng_next = has_rng_reg;
        exact_next   = exact_reg;
        start_next   = start_reg;
        acc_next     = acc_reg;
        len_next     = len_reg;
        err_next     = err_reg;
        role         = ROLE_IGNORED;

        unique case (phase_reg)
            PH_START:
            begin
                if (ch == CH_Z)
                begin
                    kw_next    = 3'd1;
                    phase_next = PH_KEYWORD;
                    role       = ROLE_KEYWORD;
                end
                else if (is_hex(ch) || ch == CH_DASH)
                begin
                    phase_next = PH_SEGMENT;
                    role       = ROLE_SEGMENT;
                end
                else if (ch == CH_SLASH)
                begin
                    phase_next = PH_OBJECT;
                    role       = ROLE_SLASH;
                end
                else
                begin
                    err_next   = 1'b1;
                    phase_next = PH_DONE;
                end
            end
            PH_KEYWORD:
            begin
                if (kw_reg < KW_LEN && ch == kw_char(kw_reg[1:0]))
                begin
                    kw_next = kw_reg + 3'd1;
                    role    = ROLE_KEYWORD;
                    if (kw_next == KW_LEN)
                    begin
                        kind_next  = 1'b0;
                        phase_next = PH_AFTER_KW;
                    end
                end
                else
                begin
                    err_next   = 1'b1;
                    phase_next = PH_DONE;
                end
            end
            PH_SEGMENT:
            begin
                if (is_hex(ch) || ch == CH_DASH)
                begin
                    role = ROLE_SEGMENT;
                end
                else if (ch == CH_SLASH)
                begin
                    phase_next = PH_OBJECT;
                    role       = ROLE_SLASH;
                end
                else
                begin
                    err_next   = 1'b1;
                    phase_next = PH_DONE;
                end
            end
            PH_OBJECT:
            begin
                if (is_hex(ch))
                begin
                    role = ROLE_OBJECT;
                end
                else if (ch == CH_LPAREN)
                begin
                    phase_next = PH_CHECKSUM;
                    role       = ROLE_CHECKSUM;
                end
                else if (ch == CH_LBRACK)
                begin
                    phase_next = PH_RNG_OPEN;
                    role       = ROLE_RANGE_SYN;
                end
                else if (ch == CH_NUL)
                begin
                    phase_next = PH_DONE;
                end
                else
                begin
                    err_next   = 1'b1;
                    phase_next = PH_DONE;
                end
            end
            PH_AFTER_KW, PH_AFTER_CK:
            begin
                // Anything else after a complete reference is trailing text.
                if (ch == CH_LPAREN && phase_reg == PH_AFTER_KW)
                begin
                    phase_next = PH_CHECKSUM;
                    role       = ROLE_CHECKSUM;
                end
                else if (ch == CH_LBRACK)
                begin
                    phase_next = PH_RNG_OPEN;
                    role       = ROLE_RANGE_SYN;
                end
                else
                begin
                    phase_next = PH_DONE;
                end
            end
            PH_CHECKSUM:
            begin
                if (ch == CH_RPAREN)
                begin
                    phase_next = PH_AFTER_CK;
                    role       = ROLE_CHECKSUM;
                end
                else if (ch == CH_NUL)
                begin
                    err_next   = 1'b1;
                    phase_next = PH_DONE;
                end
                else
                begin
                    ck_next = 1'b1;
                    role    = ROLE_CHECKSUM;
                end
            end
            PH_RNG_OPEN:
            begin
                if (ch == CH_EQUALS)
                begin
                    exact_next = 1'b1;
                    phase_next = PH_RNG_1;
                    role       = ROLE_RANGE_SYN;
                end
                else if (is_dig(ch))
                begin
                    acc_next   = acc_dig;
                    phase_next = PH_RNG_1;
                    role       = ROLE_RANGE_DIG;
                end
                else if (ch == CH_RBRACK)
                begin
                    start_next   = '0;
                    len_next     = '0;
                    has_rng_next = 1'b1;
                    phase_next   = PH_DONE;
                    role         = ROLE_RANGE_SYN;
                end
                else if (ch == CH_PLUS)
                begin
                    start_next = '0;
                    acc_next   = '0;
                    phase_next = PH_RNG_2;
                    role       = ROLE_RANGE_SYN;
                end
                else
                begin
                    err_next   = 1'b1;
                    phase_next = PH_DONE;
                end
            end
            PH_RNG_1:
            begin
                if (is_dig(ch))
                begin
                    acc_next = acc_dig;
                    role     = ROLE_RANGE_DIG;
                end
                else if (ch == CH_RBRACK)
                begin
                    start_next   = '0;
                    len_next     = acc_reg;
                    has_rng_next = 1'b1;
                    phase_next   = PH_DONE;
                    role         = ROLE_RANGE_SYN;
                end
                else if (ch == CH_PLUS && !exact_reg)
                begin
                    start_next = acc_reg;
                    acc_next   = '0;
                    phase_next = PH_RNG_2;
                    role       = ROLE_RANGE_SYN;
                end
                else
                begin
                    err_next   = 1'b1;
                    phase_next = PH_DONE;
                end
            end
            PH_RNG_2:
            begin
                if (is_dig(ch))
                begin
                    acc_next = acc_dig;
                    role     = ROLE_RANGE_DIG;
                end
                else if (ch == CH_RBRACK)
                begin
                    len_next     = acc_reg;
                    has_rng_next = 1'b1;
                    phase_next   = PH_DONE;
                    role         = ROLE_RANGE_SYN;
                end
                else
                begin
                    err_next   = 1'b1;
                    phase_next = PH_DONE;
                end
            end
            PH_DONE:
            begin
                phase_next = PH_DONE;
            end
            default:
            begin
                phase_next = PH_DONE;
            end
        endcase
    end

    // A string that stops anywhere but after an object, a keyword, a checksum,
    // a closed range or trailing text is cut off.
    always_comb
    begin
        fin_err = err_next || !(phase_next == PH_OBJECT || phase_next == PH_AFTER_KW ||
                                phase_next == PH_AFTER_CK || phase_next == PH_DONE);

        res              = '0;
        res.role         = role;
        if (last)
        begin
            res.final_res = 1'b1;
            res.status    = fin_err;
            if (!fin_err)
            begin
                res.ref_kind     = kind_next;
                res.has_checksum = ck_next;
                if (has_rng_next)
                begin
                    res.has_range   = 1'b1;
                    res.exact       = exact_next;
                    res.range_first = OUT_WIDTH'(start_next);
                    res.range_len   = OUT_WIDTH'(len_next);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_START;
            kw_reg      <= 3'd0;
            kind_reg    <= 1'b1;
            ck_reg      <= 1'b0;
            has_rng_reg <= 1'b0;
            exact_reg   <= 1'b0;
            start_reg   <= '0;
            acc_reg     <= '0;
            len_reg     <= '0;
            err_reg     <= 1'b0;
        end
        else if (fire)
        begin
            if (last)
            begin
                phase_reg   <= PH_START;
                kw_reg      <= 3'd0;
                kind_reg    <= 1'b1;
                ck_reg      <= 1'b0;
                has_rng_reg <= 1'b0;
                exact_reg   <= 1'b0;
                start_reg   <= '0;
                acc_reg     <= '0;
                len_reg     <= '0;
                err_reg     <= 1'b0;
            end
            else
            begin
                phase_reg   <= phase_next;
                kw_reg      <= kw_next;
                kind_reg    <= kind_next;
                ck_reg      <= ck_next;
                has_rng_reg <= has_rng_next;
                exact_reg   <= exact_next;
                start_reg   <= start_next;
                acc_reg     <= acc_next;
                len_reg     <= len_next;
                err_reg     <= err_next;
            end
        end
    end

    `ORP_ASSERT_NEXT(a_reset_after_last, fire && last, phase_reg == PH_START && kind_reg && !err_reg && acc_reg == '0)
    `ORP_ASSERT(a_error_silences, fire && err_reg, res.role == ROLE_IGNORED)
    `ORP_ASSERT(a_error_means_done, err_reg, phase_reg == PH_DONE)
    `ORP_ASSERT(a_keyword_count, phase_reg == PH_KEYWORD, kw_reg != 3'd0 && kw_reg < KW_LEN)

endmodule

### hdl/orp_outbuf.sv
// ----------------------------------------------------------------------------
// Object reference parser result buffer
// Output register with a skid stage so a beat is taken while a result waits.
// ----------------------------------------------------------------------------
module orp_outbuf (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  orp_pkg::result_t in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output orp_pkg::result_t out_data
);
    import orp_pkg::*;

`include "object_reference_parser_top_macros.svh"

    logic    main_valid_reg, main_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t main_data_reg,  main_data_next;
    result_t skid_data_reg,  skid_data_next;
    logic    out_fire;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_data_reg;
    assign out_fire  = main_valid_reg && out_ready;

    // in_valid is only high when in_ready is, so the skid is empty then.
    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_data_next  = main_data_reg;
        skid_data_next  = skid_data_reg;
        if (out_fire || !main_valid_reg)
        begin
            main_valid_next = skid_valid_reg || in_valid;
            main_data_next  = skid_valid_reg ? skid_data_reg : in_data;
            skid_valid_next = 1'b0;
        end
        else if (in_valid)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = in_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_data_reg <= main_data_next;
        skid_data_reg <= skid_data_next;
    end

    `ORP_ASSERT(a_skid_behind_main, skid_valid_reg, main_valid_reg)
    `ORP_ASSERT_NEXT(a_stall_fills_skid, in_valid && main_valid_reg && !out_ready, skid_valid_reg)
    `ORP_ASSERT_NEXT(a_skid_holds, skid_valid_reg && !out_ready, skid_valid_reg && main_valid_reg)

endmodule

### hdl/object_reference_parser_top.sv
// ----------------------------------------------------------------------------
// Object reference parser
// Classifies each character of an object reference and gives the verdict on
// the last one.
//
//   Channel   Dir  Beat content
//   chars     in   ch (8), last (1)
//   results   out  role (3), final_res, status, ref_kind, has_checksum,
//                  has_range, exact, range_first (63), range_len (63)
//
// One character beat is taken every cycle while chars.ready is high; its
// result beat is set by the single parse step and the output register.
// chars.ready falls only when both the output register and the skid stage
// hold results, and rises again as soon as results.ready takes one.
// Reset is asynchronous and returns the parser to the start of a reference.
// ----------------------------------------------------------------------------
module object_reference_parser_top (
    input  logic         clk,
    input  logic         rst_n,
    orp_in_if.sink       chars,
    orp_out_if.source    results
);
    import orp_pkg::*;

    logic    fire;
    logic    buf_ready;
    result_t step_res;
    result_t out_res;

    assign chars.ready = buf_ready;
    assign fire        = chars.valid && buf_ready;

    orp_parser u_parser (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .ch    (chars.ch),
        .last  (chars.last),
        .res   (step_res)
    );

    orp_outbuf u_outbuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fire),
        .in_ready  (buf_ready),
        .in_data   (step_res),
        .out_valid (results.valid),
        .out_ready (results.ready),
        .out_data  (out_res)
    );

    assign results.role         = out_res.role;
    assign results.final_res    = out_res.final_res;
    assign results.status       = out_res.status;
    assign results.ref_kind     = out_res.ref_kind;
    assign results.has_checksum = out_res.has_checksum;
    assign results.has_range    = out_res.has_range;
    assign results.exact        = out_res.exact;
    assign results.range_first  = out_res.range_first;
    assign results.range_len    = out_res.range_len;

endmodule
